### src/srp_pkg.sv
// Shared types and constants for the SLIP response parser.
package srp_pkg;

  localparam logic [7:0] SLIP_END      = 8'hC0;
  localparam logic [7:0] SLIP_ESC      = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END  = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC  = 8'hDD;
  localparam logic [7:0] DIR_RESPONSE  = 8'h01;

  localparam int unsigned HDR_LEN   = 8;
  localparam int unsigned HDR_IDX_W = 4;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // Configuration register indexes
  localparam logic REG_EXPECTED_OPCODE = 1'b0;
  localparam logic REG_TIMEOUT_TICKS   = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_BODY,
    PH_END
  } phase_t;

  typedef enum logic [1:0] {
    ST_SUCCESS,
    ST_TIMEOUT,
    ST_FRAMING,
    ST_HEADER
  } status_t;

  // Class of one queued item, decided by the front end
  typedef enum logic [2:0] {
    K_TICK,
    K_END,
    K_ESC,
    K_ESC_END,
    K_ESC_ESC,
    K_DATA
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  expected_opcode;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

### src/slip_response_parser.sv
// Top level of the SLIP response parser: config registers, front queue, back parser.
//
//  channel   direction  handshake              payload
//  in        to block   in_valid / in_ready    action, rx_byte
//  out       from block out_valid / out_ready  status, reply_value, body_length
//  cfg       to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained: the front queue takes an item each cycle while it
// has room, and the back parser retires one queued item per cycle while its result
// register is free or being emptied. With the queue empty, the item that causes a
// result is first written into the queue at its accept, then parsed into the result
// register that drives out.
// Reset clears the queue and parser state and loads the config defaults; there is
// no clearing pass. A stall on out holds the parser; the queue (QUEUE_DEPTH entries)
// keeps accepting until full, then drops in_ready.
module slip_response_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  // result transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] reply_value,
  output logic [15:0] body_length,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  srp_pkg::cfg_t  cfg;
  logic           q_valid;
  logic           q_ready;
  srp_pkg::item_t q_item;

  // Config writes are always accepted and go straight into the config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_opcode <= 8'd0;
      cfg.timeout_ticks   <= srp_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srp_pkg::REG_EXPECTED_OPCODE: cfg.expected_opcode <= cfg_data[7:0];
        srp_pkg::REG_TIMEOUT_TICKS:   cfg.timeout_ticks   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: classify each byte or tick and hold it in the queue
  srp_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // Back: decode the frame, track the timeout, register the result
  srp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .reply_value (reply_value),
    .body_length (body_length)
  );

endmodule

### src/srp_front.sv
// Front end: classifies incoming bytes and ticks and queues them for the parser.
module srp_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [7:0]       rx_byte,
  output logic             q_valid,
  input  logic             q_ready,
  output srp_pkg::item_t   q_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  srp_pkg::item_t    mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;
  srp_pkg::item_t    item_in;

  // Classify once here so the parser only looks at a small code
  always_comb begin
    item_in.data = rx_byte;
    if (action) begin
      item_in.kind = srp_pkg::K_TICK;
    end else if (rx_byte == srp_pkg::SLIP_END) begin
      item_in.kind = srp_pkg::K_END;
    end else if (rx_byte == srp_pkg::SLIP_ESC) begin
      item_in.kind = srp_pkg::K_ESC;
    end else if (rx_byte == srp_pkg::SLIP_ESC_END) begin
      item_in.kind = srp_pkg::K_ESC_END;
    end else if (rx_byte == srp_pkg::SLIP_ESC_ESC) begin
      item_in.kind = srp_pkg::K_ESC_ESC;
    end else begin
      item_in.kind = srp_pkg::K_DATA;
    end
  end

  assign in_ready = (count != CNT_W'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(DEPTH)) && !pop |=> count == CNT_W'(DEPTH))
    else $error("full queue lost an entry");

endmodule

### src/srp_back.sv
// Back end: SLIP decode, header capture, body skip, timeout and result register.
module srp_back (
  input  logic             clk,
  input  logic             rst,
  input  srp_pkg::cfg_t    cfg,
  input  logic             q_valid,
  output logic             q_ready,
  input  srp_pkg::item_t   q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [31:0]      reply_value,
  output logic [15:0]      body_length
);

  srp_pkg::phase_t                 phase, phase_next;
  logic                            esc, esc_next;
  logic [srp_pkg::HDR_IDX_W-1:0]   hidx, hidx_next;
  logic [15:0]                     bidx, bidx_next;
  logic [15:0]                     elapsed, elapsed_next;
  logic [7:0]                      hdr [srp_pkg::HDR_LEN];

  logic             take;
  logic             emit;
  srp_pkg::status_t emit_status;
  logic             hdr_we;
  logic [7:0]       dbyte;
  logic             have_byte;
  logic [15:0]      hdr_len;
  logic             hdr_full;
  logic [15:0]      el_inc;
  logic [15:0]      bidx_inc;
  srp_pkg::status_t status_q;

  assign q_ready  = !out_valid || out_ready;
  assign take     = q_valid && q_ready;
  assign hdr_len  = {hdr[3], hdr[2]};
  assign hdr_full = (hidx == srp_pkg::HDR_IDX_W'(srp_pkg::HDR_LEN));
  assign el_inc   = (elapsed == 16'hFFFF) ? elapsed : 16'(elapsed + 16'd1);
  assign bidx_inc = (bidx == 16'hFFFF) ? bidx : 16'(bidx + 16'd1);

  always_comb begin
    phase_next   = phase;
    esc_next     = esc;
    hidx_next    = hidx;
    bidx_next    = bidx;
    elapsed_next = elapsed;
    emit         = 1'b0;
    emit_status  = srp_pkg::ST_SUCCESS;
    hdr_we       = 1'b0;
    have_byte    = 1'b0;
    dbyte        = q_item.data;

    if (take) begin
      if (q_item.kind == srp_pkg::K_TICK) begin
        elapsed_next = el_inc;
        if (el_inc > cfg.timeout_ticks) begin
          emit        = 1'b1;
          emit_status = srp_pkg::ST_TIMEOUT;
        end
      end else begin
        case (phase)
          srp_pkg::PH_HUNT: begin
            if (q_item.kind == srp_pkg::K_END) begin
              phase_next = srp_pkg::PH_HEADER;
              esc_next   = 1'b0;
              hidx_next  = '0;
              bidx_next  = '0;
            end
          end
          srp_pkg::PH_END: begin
            emit = 1'b1;
            if (q_item.kind != srp_pkg::K_END) begin
              emit_status = srp_pkg::ST_FRAMING;
            end else if (hdr[0] != srp_pkg::DIR_RESPONSE ||
                         hdr[1] != cfg.expected_opcode) begin
              emit_status = srp_pkg::ST_HEADER;
            end else begin
              emit_status = srp_pkg::ST_SUCCESS;
            end
          end
          default: begin
            // Header or body: undo SLIP escaping
            if (esc) begin
              esc_next = 1'b0;
              if (q_item.kind == srp_pkg::K_ESC_END) begin
                dbyte     = srp_pkg::SLIP_END;
                have_byte = 1'b1;
              end else if (q_item.kind == srp_pkg::K_ESC_ESC) begin
                dbyte     = srp_pkg::SLIP_ESC;
                have_byte = 1'b1;
              end else begin
                emit        = 1'b1;
                emit_status = srp_pkg::ST_FRAMING;
              end
            end else if (q_item.kind == srp_pkg::K_END) begin
              emit        = 1'b1;
              emit_status = srp_pkg::ST_FRAMING;
            end else if (q_item.kind == srp_pkg::K_ESC) begin
              esc_next = 1'b1;
            end else begin
              have_byte = 1'b1;
            end

            if (have_byte) begin
              if (phase == srp_pkg::PH_HEADER) begin
                hdr_we    = 1'b1;
                hidx_next = srp_pkg::HDR_IDX_W'(hidx + 1'b1);
                if (hidx == srp_pkg::HDR_IDX_W'(srp_pkg::HDR_LEN - 1)) begin
                  bidx_next  = '0;
                  phase_next = (hdr_len != 16'd0) ? srp_pkg::PH_BODY : srp_pkg::PH_END;
                end
              end else begin
                bidx_next = bidx_inc;
                if (bidx_inc >= hdr_len) begin
                  phase_next = srp_pkg::PH_END;
                end
              end
            end
          end
        endcase
      end

      // Any result drops the frame and restarts the hunt with a fresh tick count
      if (emit) begin
        phase_next   = srp_pkg::PH_HUNT;
        esc_next     = 1'b0;
        hidx_next    = '0;
        bidx_next    = '0;
        elapsed_next = '0;
        hdr_we       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= srp_pkg::PH_HUNT;
      esc     <= 1'b0;
      hidx    <= '0;
      bidx    <= '0;
      elapsed <= '0;
    end else begin
      phase   <= phase_next;
      esc     <= esc_next;
      hidx    <= hidx_next;
      bidx    <= bidx_next;
      elapsed <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr[hidx[2:0]] <= dbyte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_q    <= emit_status;
      reply_value <= hdr_full ? {hdr[7], hdr[6], hdr[5], hdr[4]} : 32'd0;
      body_length <= hdr_full ? hdr_len : 16'd0;
    end
  end

  assign status = status_q;

  a_hidx_bound: assert property (@(posedge clk) disable iff (rst)
    hidx <= srp_pkg::HDR_IDX_W'(srp_pkg::HDR_LEN))
    else $error("header index beyond header length");

  a_body_needs_header: assert property (@(posedge clk) disable iff (rst)
    (phase == srp_pkg::PH_BODY || phase == srp_pkg::PH_END) |-> hdr_full)
    else $error("body or end phase without a full header");

  a_esc_in_frame: assert property (@(posedge clk) disable iff (rst)
    esc |-> (phase == srp_pkg::PH_HEADER || phase == srp_pkg::PH_BODY))
    else $error("escape pending outside header or body");

  a_emit_restarts: assert property (@(posedge clk) disable iff (rst)
    emit |=> phase == srp_pkg::PH_HUNT && elapsed == 16'd0 && out_valid)
    else $error("result did not restart the hunt");

endmodule
